// ----- rtl/mlru_pkg.sv -----
// Shared types and constants for the matrix LRU replacement unit.
`default_nettype none

package mlru_pkg;

  localparam int unsigned TOUCH_W  = 4;
  localparam int unsigned CHOSEN_W = 4;

  typedef enum logic {
    ACT_TOUCH   = 1'b0,
    ACT_REPLACE = 1'b1
  } action_t;

endpackage

`default_nettype wire

// ----- rtl/matrix_lru_replacement_unit.sv -----
// Matrix LRU replacement unit for FRAMES page frames.
// Input channel (in_valid / in_stall): in_action selects touch (0) or replace (1);
// in_touch_frame names the frame for a touch and is ignored for a replace.
// Result channel (out_valid / out_stall): out_chosen_frame is the victim of a
// replace or the echoed frame of a touch (low 4 bits of the frame index).
// Every input transaction yields exactly one result transaction.
// The age matrix sits in a row memory with a registered read port and is
// walked one row per cycle by a single comparator and a single column clear.
// A touch runs an update pass over all rows before its result is loaded;
// a replace runs a compare pass over all rows, then the update pass.
// A touch of a frame at or above FRAMES skips the update pass and goes
// straight to the finish state to load its result. One transaction is in
// work at a time and in_stall is high while it runs, so the next accept
// waits until the current result has been loaded into the output register.
// A finished result sits in the output register; the next transaction is
// accepted while it waits. If the receiver stalls and the next result is
// ready, the unit holds it and keeps in_stall high until the register frees.
// Reset (rst_n low, synchronous) clears the matrix to all zeros through the
// per-row valid bits at once, empties the output register and returns idle.
`default_nettype none

module matrix_lru_replacement_unit #(
  parameter int FRAMES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_action,
  input  wire logic [mlru_pkg::TOUCH_W-1:0]  in_touch_frame,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mlru_pkg::CHOSEN_W-1:0]      out_chosen_frame
);

  import mlru_pkg::*;

  localparam int FW = $clog2(FRAMES);
  localparam logic [FW-1:0]     LAST_ROW = FW'(FRAMES - 1);
  localparam logic [FRAMES-1:0] ROW_ONES = '1;
  localparam logic [FRAMES-1:0] COL0_BIT = {1'b1, {(FRAMES-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t              state_r;
  logic [FW-1:0]       cnt_r;
  logic                issue_r;
  logic                rd_vld_r;
  logic [FW-1:0]       rd_idx_r;
  logic [FRAMES-1:0]   best_val_r;
  logic [FW-1:0]       best_idx_r;
  logic [FW-1:0]       frame_r;
  logic [CHOSEN_W-1:0] chosen_r;
  logic                out_valid_r;
  logic [CHOSEN_W-1:0] out_frame_r;

  logic                rd_en;
  logic [FRAMES-1:0]   rd_data;
  logic                wr_en;
  logic [FRAMES-1:0]   wr_data;
  logic [FRAMES-1:0]   col_bit;
  logic                take;
  logic [FW-1:0]       win_idx;
  logic                in_fire;
  logic                last_data;

  assign in_fire   = in_valid && (state_r == S_IDLE);
  assign rd_en     = ((state_r == S_SCAN) || (state_r == S_UPDATE)) && issue_r;
  assign last_data = rd_vld_r && (rd_idx_r == LAST_ROW);

  // Row 0 always seeds the minimum; strict less keeps the lowest index on ties.
  assign take    = rd_vld_r && ((rd_idx_r == '0) || (rd_data < best_val_r));
  assign win_idx = take ? rd_idx_r : best_idx_r;

  // Column f is bit FRAMES-1-f of a row.
  assign col_bit = COL0_BIT >> frame_r;
  assign wr_en   = (state_r == S_UPDATE) && rd_vld_r;
  assign wr_data = ((rd_idx_r == frame_r) ? ROW_ONES : rd_data) & ~col_bit;

  mlru_row_mem #(
    .FRAMES (FRAMES)
  ) u_row_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (cnt_r),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (rd_idx_r),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      rd_idx_r <= cnt_r;
      // The finish state reloads the register itself.
      if (out_valid_r && !out_stall && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end
      if (rd_en) begin
        cnt_r <= cnt_r + FW'(1);
        if (cnt_r == LAST_ROW) begin
          issue_r <= 1'b0;
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cnt_r <= '0;
            if (action_t'(in_action) == ACT_REPLACE) begin
              issue_r <= 1'b1;
              state_r <= S_SCAN;
            end else begin
              chosen_r <= CHOSEN_W'(in_touch_frame);
              frame_r  <= FW'(in_touch_frame);
              // Drop the update for a frame outside the matrix.
              if (int'(in_touch_frame) < FRAMES) begin
                issue_r <= 1'b1;
                state_r <= S_UPDATE;
              end else begin
                state_r <= S_FINISH;
              end
            end
          end
        end
        S_SCAN: begin
          if (take) begin
            best_val_r <= rd_data;
            best_idx_r <= rd_idx_r;
          end
          if (last_data) begin
            frame_r  <= win_idx;
            chosen_r <= CHOSEN_W'(win_idx);
            cnt_r    <= '0;
            issue_r  <= 1'b1;
            state_r  <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (last_data) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold the result until the output register frees.
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_frame_r <= chosen_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_chosen_frame = out_frame_r;

endmodule

`default_nettype wire

// ----- rtl/mlru_row_mem.sv -----
// Age matrix row storage: one write port, one registered read port, per-row valid bits.
`default_nettype none

module mlru_row_mem #(
  parameter int FRAMES = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       rd_en,
  input  wire logic [$clog2(FRAMES)-1:0]  rd_addr,
  output logic      [FRAMES-1:0]          rd_data,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(FRAMES)-1:0]  wr_addr,
  input  wire logic [FRAMES-1:0]          wr_data
);

  logic [FRAMES-1:0] mem_q [FRAMES];
  logic [FRAMES-1:0] row_vld_r;
  logic [FRAMES-1:0] rd_data_r;
  logic              rd_row_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_q[rd_addr];
    end
  end

  // A row never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r    <= '0;
      rd_row_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_row_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_row_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

// ----- rtl/mlru_checker.sv -----
// Port-level checks for the matrix LRU replacement unit, bound to the top level.
`default_nettype none

module mlru_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [mlru_pkg::CHOSEN_W-1:0] out_chosen_frame
);

  import mlru_pkg::*;

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pend_r;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;

  // Count transactions accepted but not yet delivered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else if (in_fire && !out_fire) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_fire && !in_fire) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> in_stall)
    else $error("input not stalled while a transaction is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_chosen_frame))
    else $error("stalled result changed or dropped");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without an accepted transaction");

  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> pend_r <= 2'd1)
    else $error("transaction accepted with two results outstanding");

endmodule

bind matrix_lru_replacement_unit mlru_checker u_mlru_checker (.*);

`default_nettype wire
